@@ sv/edge_function_pixel_coverage_defines.svh @@
// ----------------------------------------------------------------------------
// edge_function_pixel_coverage_defines
// assertion macros used by the checker file of this block
// ----------------------------------------------------------------------------
`ifndef EDGE_FUNCTION_PIXEL_COVERAGE_DEFINES_SVH
`define EDGE_FUNCTION_PIXEL_COVERAGE_DEFINES_SVH

// same-cycle implication
`define EFPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EFPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/efpc_pkg.sv @@
// ----------------------------------------------------------------------------
// efpc_pkg
// shared types and field widths of the pixel coverage pipeline
// ----------------------------------------------------------------------------
package efpc_pkg;

	localparam int COORD_W = 16;
	localparam int PIX_W   = 11;
	localparam int WGT_W   = 16;

	typedef struct packed {
		logic covered;
		logic degenerate;
		logic neg_b;
		logic neg_c;
	} efpc_flags_t;

	typedef struct packed {
		logic             covered;
		logic             degenerate;
		logic [WGT_W-1:0] weight_a;
		logic [WGT_W-1:0] weight_b;
		logic [WGT_W-1:0] weight_c;
	} efpc_res_t;

endpackage

@@ sv/efpc_edge.sv @@
// ----------------------------------------------------------------------------
// efpc_edge
// four-stage edge function unit: differences, products, edges, magnitudes
// ----------------------------------------------------------------------------
module efpc_edge #(
	parameter int COORD_FRAC_BITS = 4,
	parameter int DW = 18,
	parameter int EW = 37
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_v,
	input  logic signed [efpc_pkg::COORD_W-1:0] ax,
	input  logic signed [efpc_pkg::COORD_W-1:0] ay,
	input  logic signed [efpc_pkg::COORD_W-1:0] bx,
	input  logic signed [efpc_pkg::COORD_W-1:0] by,
	input  logic signed [efpc_pkg::COORD_W-1:0] cx,
	input  logic signed [efpc_pkg::COORD_W-1:0] cy,
	input  logic        [efpc_pkg::PIX_W-1:0]   pixel_x,
	input  logic        [efpc_pkg::PIX_W-1:0]   pixel_y,
	output logic                                out_v,
	output efpc_pkg::efpc_flags_t               out_flags,
	output logic        [EW-1:0]                out_d,
	output logic        [EW-1:0]                out_nb,
	output logic        [EW-1:0]                out_nc
);

	logic signed [DW-1:0] axd, ayd, bxd, byd, cxd, cyd, pxc, pyc;
	logic signed [DW-1:0] bax_s1, bay_s1, cbx_s1, cby_s1, acx_s1, acy_s1, cax_s1, cay_s1;
	logic signed [DW-1:0] pax_s1, pay_s1, pbx_s1, pby_s1, pcx_s1, pcy_s1;
	logic signed [2*DW-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2, m6_s2, m7_s2;
	logic signed [EW-1:0] eab_s3, ebc_s3, eca_s3, d_s3;
	logic v_s1, v_s2, v_s3, v_s4;
	efpc_pkg::efpc_flags_t flags_s4;
	logic [EW-1:0] d_s4, nb_s4, nc_s4;

	assign axd = DW'(ax) <<< 1;
	assign ayd = DW'(ay) <<< 1;
	assign bxd = DW'(bx) <<< 1;
	assign byd = DW'(by) <<< 1;
	assign cxd = DW'(cx) <<< 1;
	assign cyd = DW'(cy) <<< 1;
	assign pxc = $signed(DW'({pixel_x, 1'b1}) << COORD_FRAC_BITS);
	assign pyc = $signed(DW'({pixel_y, 1'b1}) << COORD_FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bax_s1 <= bxd - axd;
			bay_s1 <= byd - ayd;
			cbx_s1 <= cxd - bxd;
			cby_s1 <= cyd - byd;
			acx_s1 <= axd - cxd;
			acy_s1 <= ayd - cyd;
			cax_s1 <= cxd - axd;
			cay_s1 <= cyd - ayd;
			pax_s1 <= pxc - axd;
			pay_s1 <= pyc - ayd;
			pbx_s1 <= pxc - bxd;
			pby_s1 <= pyc - byd;
			pcx_s1 <= pxc - cxd;
			pcy_s1 <= pyc - cyd;

			m0_s2 <= bax_s1 * pay_s1;
			m1_s2 <= bay_s1 * pax_s1;
			m2_s2 <= cbx_s1 * pby_s1;
			m3_s2 <= cby_s1 * pbx_s1;
			m4_s2 <= acx_s1 * pcy_s1;
			m5_s2 <= acy_s1 * pcx_s1;
			m6_s2 <= bax_s1 * cay_s1;
			m7_s2 <= bay_s1 * cax_s1;

			eab_s3 <= EW'(m0_s2) - EW'(m1_s2);
			ebc_s3 <= EW'(m2_s2) - EW'(m3_s2);
			eca_s3 <= EW'(m4_s2) - EW'(m5_s2);
			d_s3   <= EW'(m6_s2) - EW'(m7_s2);

			flags_s4.covered    <= !eab_s3[EW-1] && !ebc_s3[EW-1] && !eca_s3[EW-1] &&
				(d_s3 != '0);
			flags_s4.degenerate <= (d_s3 == '0);
			flags_s4.neg_b      <= (eca_s3 != '0) && (eca_s3[EW-1] ^ d_s3[EW-1]);
			flags_s4.neg_c      <= (eab_s3 != '0) && (eab_s3[EW-1] ^ d_s3[EW-1]);
			d_s4  <= d_s3[EW-1] ? $unsigned(-d_s3) : $unsigned(d_s3);
			nb_s4 <= eca_s3[EW-1] ? $unsigned(-eca_s3) : $unsigned(eca_s3);
			nc_s4 <= eab_s3[EW-1] ? $unsigned(-eab_s3) : $unsigned(eab_s3);
		end
	end

	assign out_v     = v_s4;
	assign out_flags = flags_s4;
	assign out_d     = d_s4;
	assign out_nb    = nb_s4;
	assign out_nc    = nc_s4;

endmodule

@@ sv/efpc_div_step.sv @@
// ----------------------------------------------------------------------------
// efpc_div_step
// one restoring division step for the beta and gamma lanes
// ----------------------------------------------------------------------------
module efpc_div_step #(
	parameter int EW = 37,
	parameter int NW = 53
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_v,
	input  efpc_pkg::efpc_flags_t in_flags,
	input  logic [EW-1:0]         in_d,
	input  logic [NW-1:0]         in_num_b,
	input  logic [EW-1:0]         in_rem_b,
	input  logic [NW-1:0]         in_num_c,
	input  logic [EW-1:0]         in_rem_c,
	output logic                  out_v,
	output efpc_pkg::efpc_flags_t out_flags,
	output logic [EW-1:0]         out_d,
	output logic [NW-1:0]         out_num_b,
	output logic [EW-1:0]         out_rem_b,
	output logic [NW-1:0]         out_num_c,
	output logic [EW-1:0]         out_rem_c
);

	logic [EW:0] rt_b, rt_c, dx;
	logic        ge_b, ge_c;

	assign dx   = {1'b0, in_d};
	assign rt_b = {in_rem_b, in_num_b[NW-1]};
	assign rt_c = {in_rem_c, in_num_c[NW-1]};
	assign ge_b = (rt_b >= dx);
	assign ge_c = (rt_c >= dx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_flags <= in_flags;
			out_d     <= in_d;
			out_num_b <= {in_num_b[NW-2:0], ge_b};
			out_num_c <= {in_num_c[NW-2:0], ge_c};
			out_rem_b <= ge_b ? EW'(rt_b - dx) : EW'(rt_b);
			out_rem_c <= ge_c ? EW'(rt_c - dx) : EW'(rt_c);
		end
	end

endmodule

@@ sv/efpc_fin.sv @@
// ----------------------------------------------------------------------------
// efpc_fin
// floor correction of the quotients, alpha, saturation to weight fields
// ----------------------------------------------------------------------------
module efpc_fin #(
	parameter int EW = 37,
	parameter int NW = 53,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_v,
	input  efpc_pkg::efpc_flags_t in_flags,
	input  logic [NW-1:0]         in_qb,
	input  logic [EW-1:0]         in_rem_b,
	input  logic [NW-1:0]         in_qc,
	input  logic [EW-1:0]         in_rem_c,
	output logic                  out_v,
	output efpc_pkg::efpc_res_t   out_res
);

	localparam int QW = NW + 1;
	localparam int AW = QW + 2;

	function automatic logic [WEIGHT_BITS-1:0] sat_w(input logic signed [AW-1:0] v);
		logic [WEIGHT_BITS-1:0] r;
		if (v[AW-1])
			r = '0;
		else if (v[AW-2:WEIGHT_BITS] != '0)
			r = '1;
		else
			r = v[WEIGHT_BITS-1:0];
		return r;
	endfunction

	logic                  v_s1, v_s2;
	efpc_pkg::efpc_flags_t flags_s1;
	logic signed [QW-1:0]  qb_s1, qc_s1;
	logic signed [AW-1:0]  one, alpha;
	efpc_pkg::efpc_res_t   res_s2;

	assign one   = AW'(1) <<< WEIGHT_BITS;
	assign alpha = one - AW'(qb_s1) - AW'(qc_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1 <= in_flags;
			qb_s1 <= in_flags.neg_b ?
				$signed(-({1'b0, in_qb} + QW'(in_rem_b != '0))) : $signed({1'b0, in_qb});
			qc_s1 <= in_flags.neg_c ?
				$signed(-({1'b0, in_qc} + QW'(in_rem_c != '0))) : $signed({1'b0, in_qc});

			res_s2.covered    <= flags_s1.covered;
			res_s2.degenerate <= flags_s1.degenerate;
			if (flags_s1.degenerate) begin
				res_s2.weight_a <= '0;
				res_s2.weight_b <= '0;
				res_s2.weight_c <= '0;
			end else begin
				res_s2.weight_a <= efpc_pkg::WGT_W'(sat_w(alpha));
				res_s2.weight_b <= efpc_pkg::WGT_W'(sat_w(AW'(qb_s1)));
				res_s2.weight_c <= efpc_pkg::WGT_W'(sat_w(AW'(qc_s1)));
			end
		end
	end

	assign out_v   = v_s2;
	assign out_res = res_s2;

endmodule

@@ sv/edge_function_pixel_coverage.sv @@
// ----------------------------------------------------------------------------
// edge_function_pixel_coverage
// half-space pixel coverage test with barycentric weights
// ----------------------------------------------------------------------------
// Input beats carry one triangle (ax..cy, signed, COORD_FRAC_BITS fraction
// bits) and one pixel (pixel_x, pixel_y), sampled at the pixel center; a beat
// is taken when item_valid is high and item_stall low. Each input beat yields
// one result beat (covered, degenerate, weight_a/b/c) on res_valid/res_stall.
// One beat is accepted every cycle while item_stall is low. Four stages
// form the edge values, a chain of one restoring division step per
// quotient bit forms beta and gamma, two stages saturate.
// When res_stall holds a waiting result, one more result parks in a skid
// register; only then does item_stall rise, and the whole pipeline holds.
// Reset clears all valid bits; no result is pending afterwards.
// A zero-area triangle reports degenerate with zero weights, uncovered.
// ----------------------------------------------------------------------------
module edge_function_pixel_coverage #(
	parameter int COORD_FRAC_BITS = 4,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic signed [efpc_pkg::COORD_W-1:0] ax,
	input  logic signed [efpc_pkg::COORD_W-1:0] ay,
	input  logic signed [efpc_pkg::COORD_W-1:0] bx,
	input  logic signed [efpc_pkg::COORD_W-1:0] by,
	input  logic signed [efpc_pkg::COORD_W-1:0] cx,
	input  logic signed [efpc_pkg::COORD_W-1:0] cy,
	input  logic        [efpc_pkg::PIX_W-1:0]   pixel_x,
	input  logic        [efpc_pkg::PIX_W-1:0]   pixel_y,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                covered,
	output logic                                degenerate,
	output logic        [efpc_pkg::WGT_W-1:0]   weight_a,
	output logic        [efpc_pkg::WGT_W-1:0]   weight_b,
	output logic        [efpc_pkg::WGT_W-1:0]   weight_c
);

	localparam int PW = 13 + COORD_FRAC_BITS;
	localparam int VW = efpc_pkg::COORD_W + 1;
	localparam int DW = ((PW > VW) ? PW : VW) + 1;
	localparam int EW = 2 * DW + 1;
	localparam int NW = EW + WEIGHT_BITS;

	logic                  en;
	logic                  sv_v   [0:NW];
	efpc_pkg::efpc_flags_t sv_fl  [0:NW];
	logic [EW-1:0]         sv_d   [0:NW];
	logic [NW-1:0]         sv_nb  [0:NW];
	logic [EW-1:0]         sv_rb  [0:NW];
	logic [NW-1:0]         sv_nc  [0:NW];
	logic [EW-1:0]         sv_rc  [0:NW];
	logic [EW-1:0]         mag_b, mag_c;
	logic                  fin_v;
	efpc_pkg::efpc_res_t   fin_res;
	logic                  out_v_q, skid_v_q;
	efpc_pkg::efpc_res_t   out_q, skid_q;
	logic                  out_free;

	assign en         = !skid_v_q;
	assign item_stall = skid_v_q;

	efpc_edge #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.DW(DW),
		.EW(EW)
	) u_edge (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(item_valid),
		.ax(ax),
		.ay(ay),
		.bx(bx),
		.by(by),
		.cx(cx),
		.cy(cy),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.out_v(sv_v[0]),
		.out_flags(sv_fl[0]),
		.out_d(sv_d[0]),
		.out_nb(mag_b),
		.out_nc(mag_c)
	);

	assign sv_nb[0] = {mag_b, {WEIGHT_BITS{1'b0}}};
	assign sv_nc[0] = {mag_c, {WEIGHT_BITS{1'b0}}};
	assign sv_rb[0] = '0;
	assign sv_rc[0] = '0;

	for (genvar i = 0; i < NW; i++) begin : g_div
		efpc_div_step #(
			.EW(EW),
			.NW(NW)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_v(sv_v[i]),
			.in_flags(sv_fl[i]),
			.in_d(sv_d[i]),
			.in_num_b(sv_nb[i]),
			.in_rem_b(sv_rb[i]),
			.in_num_c(sv_nc[i]),
			.in_rem_c(sv_rc[i]),
			.out_v(sv_v[i+1]),
			.out_flags(sv_fl[i+1]),
			.out_d(sv_d[i+1]),
			.out_num_b(sv_nb[i+1]),
			.out_rem_b(sv_rb[i+1]),
			.out_num_c(sv_nc[i+1]),
			.out_rem_c(sv_rc[i+1])
		);
	end

	efpc_fin #(
		.EW(EW),
		.NW(NW),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_fin (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(sv_v[NW]),
		.in_flags(sv_fl[NW]),
		.in_qb(sv_nb[NW]),
		.in_rem_b(sv_rb[NW]),
		.in_qc(sv_nc[NW]),
		.in_rem_c(sv_rc[NW]),
		.out_v(fin_v),
		.out_res(fin_res)
	);

	// output register with one skid entry behind it
	assign out_free = !out_v_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || fin_v;
			skid_v_q <= 1'b0;
		end else if (fin_v && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : fin_res;
		end else if (fin_v && en) begin
			skid_q <= fin_res;
		end
	end

	assign res_valid  = out_v_q;
	assign covered    = out_q.covered;
	assign degenerate = out_q.degenerate;
	assign weight_a   = out_q.weight_a;
	assign weight_b   = out_q.weight_b;
	assign weight_c   = out_q.weight_c;

endmodule

@@ sv/efpc_checker.sv @@
// ----------------------------------------------------------------------------
// efpc_checker
// port-level checks of the pixel coverage block, bound to the top level
// ----------------------------------------------------------------------------
`include "edge_function_pixel_coverage_defines.svh"

module efpc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_stall,
	input logic                              res_valid,
	input logic                              res_stall,
	input logic                              covered,
	input logic                              degenerate,
	input logic [efpc_pkg::WGT_W-1:0]        weight_a,
	input logic [efpc_pkg::WGT_W-1:0]        weight_b,
	input logic [efpc_pkg::WGT_W-1:0]        weight_c
);

	`EFPC_ASSERT_NOW(a_degen_result, res_valid && degenerate, !covered && weight_a == '0 && weight_b == '0 && weight_c == '0, "degenerate beat with coverage or weights")

	`EFPC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(covered) && $stable(degenerate) && $stable(weight_a) && $stable(weight_b) && $stable(weight_c), "stalled result beat changed")

	`EFPC_ASSERT_NOW(a_stall_cause, $rose(item_stall), $past(res_valid && res_stall), "input stall without output stall")

	`EFPC_ASSERT_NEXT(a_stall_release, item_stall && !res_stall, !item_stall, "input stall held after skid drained")

endmodule

bind edge_function_pixel_coverage efpc_checker u_efpc_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// pixel coverage and barycentric weight check with random idling on both sides
// ----------------------------------------------------------------------------
// A driver streams triangle/pixel beats from a queue, and a monitor compares
// each result beat with the expectation computed in exact integer arithmetic.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic signed [efpc_pkg::COORD_W-1:0] ax, ay, bx, by, cx, cy;
		logic [efpc_pkg::PIX_W-1:0] px, py;
	} tri_pix_t;

	localparam int LATENCY = 60;
	localparam longint LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_stall;
	logic signed [efpc_pkg::COORD_W-1:0] ax = 0, ay = 0, bx = 0, by = 0, cx = 0, cy = 0;
	logic [efpc_pkg::PIX_W-1:0] pixel_x = 0, pixel_y = 0;
	logic res_valid;
	logic res_stall = 0;
	logic covered, degenerate;
	logic [efpc_pkg::WGT_W-1:0] weight_a, weight_b, weight_c;

	tri_pix_t pending_q[$];
	efpc_pkg::efpc_res_t weights_q[$];
	int errors = 0;
	longint cycles = 0;
	bit hold_off = 0;
	bit in_taken = 0;
	int send_gap = 0;
	int stall_gap = 0;

	edge_function_pixel_coverage i_dut (.*);

	always #6 clk = ~clk;

	function automatic longint edge_val(longint ox, longint oy, longint qx, longint qy,
			longint rx, longint ry);
		return (qx - ox) * (ry - oy) - (qy - oy) * (rx - ox);
	endfunction

	function automatic void floor_split(longint num, longint d, output longint whole,
			output longint frac);
		longint q, r;
		q = num / d;
		r = num % d;
		if (r < 0) begin
			r += d;
			q -= 1;
		end
		whole = q;
		frac = (r <<< 16) / d;
	endfunction

	function automatic logic [efpc_pkg::WGT_W-1:0] clamp_weight(longint v);
		if (v < 0) return '0;
		if (v > 65535) return '1;
		return v[efpc_pkg::WGT_W-1:0];
	endfunction

	function automatic efpc_pkg::efpc_res_t predict_weights(tri_pix_t t);
		efpc_pkg::efpc_res_t r;
		longint vax, vay, vbx, vby, vcx, vcy, ppx, ppy;
		longint e_ab, e_bc, e_ca, d, nb, nc, wb, fb, wc, fc, beta, gamma, alpha, k;
		vax = 2 * longint'(t.ax); vay = 2 * longint'(t.ay);
		vbx = 2 * longint'(t.bx); vby = 2 * longint'(t.by);
		vcx = 2 * longint'(t.cx); vcy = 2 * longint'(t.cy);
		ppx = (2 * longint'(t.px) + 1) <<< 4;
		ppy = (2 * longint'(t.py) + 1) <<< 4;
		e_ab = edge_val(vax, vay, vbx, vby, ppx, ppy);
		e_bc = edge_val(vbx, vby, vcx, vcy, ppx, ppy);
		e_ca = edge_val(vcx, vcy, vax, vay, ppx, ppy);
		d = edge_val(vax, vay, vbx, vby, vcx, vcy);
		r = '0;
		if (d == 0) begin
			r.degenerate = 1;
			return r;
		end
		r.covered = e_ab >= 0 && e_bc >= 0 && e_ca >= 0;
		nb = e_ca;
		nc = e_ab;
		if (d < 0) begin
			d = -d;
			nb = -nb;
			nc = -nc;
		end
		floor_split(nb, d, wb, fb);
		floor_split(nc, d, wc, fc);
		beta = wb < 0 ? -1 : (wb >= 1 ? 65536 : fb);
		gamma = wc < 0 ? -1 : (wc >= 1 ? 65536 : fc);
		k = wb + wc;
		if (k >= 2) alpha = -1;
		else if (k <= -2) alpha = 65536;
		else alpha = 65536 * (1 - k) - fb - fc;
		r.weight_a = clamp_weight(alpha);
		r.weight_b = clamp_weight(beta);
		r.weight_c = clamp_weight(gamma);
		return r;
	endfunction

	function automatic tri_pix_t make_item(int ax_, int ay_, int bx_, int by_, int cx_,
			int cy_, int px_, int py_);
		tri_pix_t t;
		t.ax = efpc_pkg::COORD_W'(ax_); t.ay = efpc_pkg::COORD_W'(ay_);
		t.bx = efpc_pkg::COORD_W'(bx_); t.by = efpc_pkg::COORD_W'(by_);
		t.cx = efpc_pkg::COORD_W'(cx_); t.cy = efpc_pkg::COORD_W'(cy_);
		t.px = efpc_pkg::PIX_W'(px_); t.py = efpc_pkg::PIX_W'(py_);
		return t;
	endfunction

	function automatic void enqueue_item(tri_pix_t t);
		pending_q.insert(pending_q.size(), t);
	endfunction

	function automatic logic signed [efpc_pkg::COORD_W-1:0] near_coord(int base);
		return efpc_pkg::COORD_W'(base + $urandom_range(0, 2047) - 1024);
	endfunction

	function automatic logic signed [efpc_pkg::COORD_W-1:0] rand_coord();
		return efpc_pkg::COORD_W'($urandom);
	endfunction

	function automatic logic [efpc_pkg::PIX_W-1:0] rand_pix();
		return efpc_pkg::PIX_W'($urandom);
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				send_gap = $urandom_range(0, 15);
				if ($urandom_range(0, 3) == 0) send_gap = 0;
			end
			if (!item_valid || in_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 0;
				end else if (!hold_off && pending_q.size() > 0) begin
					tri_pix_t t;
					t = pending_q.pop_front();
					ax <= t.ax; ay <= t.ay; bx <= t.bx; by <= t.by;
					cx <= t.cx; cy <= t.cy; pixel_x <= t.px; pixel_y <= t.py;
					weights_q.insert(weights_q.size(), predict_weights(t));
					item_valid <= 1;
				end else begin
					item_valid <= 0;
				end
			end
			if (stall_gap > 0) begin
				res_stall <= 1;
				stall_gap--;
			end else begin
				res_stall <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
		in_taken = arst_n && item_valid && !item_stall;
		if (arst_n && res_valid && !res_stall) begin
			if (weights_q.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				errors++;
			end else begin
				efpc_pkg::efpc_res_t e;
				e = weights_q.pop_front();
				if (covered !== e.covered) begin
					$display("%0t: covered exp %0d got %0d", $time, e.covered, covered);
					errors++;
				end
				if (degenerate !== e.degenerate) begin
					$display("%0t: degenerate exp %0d got %0d", $time, e.degenerate,
						degenerate);
					errors++;
				end
				if (weight_a !== e.weight_a) begin
					$display("%0t: weight_a exp %h got %h", $time, e.weight_a, weight_a);
					errors++;
				end
				if (weight_b !== e.weight_b) begin
					$display("%0t: weight_b exp %h got %h", $time, e.weight_b, weight_b);
					errors++;
				end
				if (weight_c !== e.weight_c) begin
					$display("%0t: weight_c exp %h got %h", $time, e.weight_c, weight_c);
					errors++;
				end
			end
			if ($urandom_range(0, 1) == 0) stall_gap = $urandom_range(0, 15);
		end
	end

	initial begin
		int sel, bxp, byp;
		// directed: extremes, degenerate, clockwise, inside, outside
		enqueue_item(make_item(0, 0, 0, 0, 0, 0, 0, 0));
		enqueue_item(make_item(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
		enqueue_item(make_item(-32768, -32768, -32768, 32767, 32767, -32768,
			2047, 2047));
		enqueue_item(make_item(0, 0, 1600, 0, 0, 1600, 10, 10));
		enqueue_item(make_item(0, 0, 0, 1600, 1600, 0, 10, 10));
		enqueue_item(make_item(0, 0, 1600, 0, 0, 1600, 200, 200));
		enqueue_item(make_item(0, 0, 1600, 0, 0, 1600, 0, 0));
		enqueue_item(make_item(0, 0, 16, 16, 32, 32, 5, 5));
		enqueue_item(make_item(32767, 32767, 32767, 32767, 32767, 32767, 2047, 0));
		enqueue_item(make_item(-32768, 32767, 32767, 32767, 0, -32768, 1024, 2047));
		enqueue_item(make_item(0, 0, 1, 0, 0, 1, 0, 0));
		enqueue_item(make_item(0, 0, 32767, 0, 0, 32767, 2047, 0));
		enqueue_item(make_item(0, 0, 32767, 0, 0, 32767, 0, 2047));
		enqueue_item(make_item(0, 0, 32767, 0, 0, 32767, 1023, 1023));
		enqueue_item(make_item(-32768, -32768, 32767, 32767, -32768, 32767, 0, 2047));
		for (int i = 0; i < 1500; i++) begin
			tri_pix_t t;
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				// small triangle near the pixel, so weights land in range
				t.px = efpc_pkg::PIX_W'($urandom_range(0, 2047));
				t.py = efpc_pkg::PIX_W'($urandom_range(0, 2047));
				bxp = t.px * 16;
				byp = t.py * 16;
				t.ax = near_coord(bxp); t.ay = near_coord(byp);
				t.bx = near_coord(bxp); t.by = near_coord(byp);
				t.cx = near_coord(bxp); t.cy = near_coord(byp);
			end else if (sel < 8) begin
				t.ax = rand_coord(); t.ay = rand_coord(); t.bx = rand_coord();
				t.by = rand_coord(); t.cx = rand_coord(); t.cy = rand_coord();
				t.px = rand_pix(); t.py = rand_pix();
			end else begin
				// collinear or repeated vertices
				t.ax = rand_coord(); t.ay = rand_coord();
				t.bx = rand_coord(); t.by = rand_coord();
				if (sel == 8) begin
					t.cx = t.ax; t.cy = t.ay;
				end else begin
					t.cx = t.ax + t.ax - t.bx; t.cy = t.ay + t.ay - t.by;
				end
				t.px = rand_pix(); t.py = rand_pix();
			end
			enqueue_item(t);
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// hold the sender until the pipe drains once
		wait (pending_q.size() < 1300);
		hold_off = 1;
		wait (weights_q.size() == 0);
		hold_off = 0;
		wait (pending_q.size() == 0);
		@(posedge clk);
		while (item_valid) @(posedge clk);
		while (weights_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
